// File: rtl/core/voxel_ray_traversal_top_assert.svh
// Assertion macros for the voxel ray traversal top level.
`ifndef VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH

// Check that expr holds in the same cycle as cond.
`define VRT_ASSERT_NOW(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Check that expr holds in the cycle after cond.
`define VRT_ASSERT_NEXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: rtl/core/vrt_pkg.sv
// Shared types and constants of the voxel ray traversal block.
package vrt_pkg;

   localparam int NUM_AXES = 3;
   localparam int AXIS_W = 2;
   localparam int HEIGHT_W = 15;
   localparam int RECIP_STEPS = 31;
   localparam int RECIP_CNT_W = 5;

   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
   localparam logic [30:0] RECIP_DIVIDEND = 31'h4000_0000;
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;
   localparam logic [HEIGHT_W-1:0] DEFAULT_HEIGHT = 15'd256;

   localparam logic OP_START = 1'b0;
   localparam logic OP_ANSWER = 1'b1;

   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   typedef enum logic [1:0] {
      KIND_QUERY = 2'd0,
      KIND_HIT   = 2'd1,
      KIND_MISS  = 2'd2
   } kind_type;

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      kind_type          kind;
      logic [2:0][15:0]  voxel;
      logic [2:0][15:0]  prior;
      logic [2:0]        face;
      logic [31:0]       distance;
   } rsp_type;

endpackage

// File: rtl/core/vrt_req_if.sv
// Request channel of the voxel ray traversal block.
interface vrt_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic [31:0]        max_distance;
   logic               voxel_solid;

   modport source (
      output valid, op, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
      output max_distance, voxel_solid,
      input  ready
   );

   modport sink (
      input  valid, op, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
      input  max_distance, voxel_solid,
      output ready
   );
endinterface

// File: rtl/core/vrt_rsp_if.sv
// Response channel of the voxel ray traversal block.
interface vrt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] voxel_x;
   logic signed [15:0] voxel_y;
   logic signed [15:0] voxel_z;
   logic signed [15:0] prior_x;
   logic signed [15:0] prior_y;
   logic signed [15:0] prior_z;
   logic [2:0]         face;
   logic [31:0]        distance;

   modport source (
      output valid, kind, voxel_x, voxel_y, voxel_z, prior_x, prior_y, prior_z,
      output face, distance,
      input  ready
   );

   modport sink (
      input  valid, kind, voxel_x, voxel_y, voxel_z, prior_x, prior_y, prior_z,
      input  face, distance,
      output ready
   );
endinterface

// File: rtl/core/vrt_recip.sv
// Bit-serial restoring divider that forms 2^30 / divisor, one quotient bit per cycle.
module vrt_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [30:0] quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [vrt_pkg::RECIP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]                      rem_ff, rem_in;
   logic [30:0]                      quo_ff, quo_in;
   logic [15:0]                      div_ff, div_in;
   logic [16:0]                      trial;
   logic                             fits;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   always_comb begin
      trial   = {rem_ff, quo_ff[30]};
      fits    = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = vrt_pkg::RECIP_CNT_W'(vrt_pkg::RECIP_STEPS);
         rem_in  = '0;
         quo_in  = vrt_pkg::RECIP_DIVIDEND;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
         quo_in = {quo_ff[29:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == vrt_pkg::RECIP_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/voxel_ray_traversal_top.sv
// Top level of the voxel ray traversal block: sequencer, ray state and response register.
// Walks a ray through a voxel grid one voxel per request. A start request loads
// origin, direction and limit; the block then forms each axis's crossing step with
// the shared bit-serial reciprocal divider (launch, wait for its 31 quotient bits,
// then multiply for the first boundary), and the first response follows the last
// axis. An answer request for the queried voxel picks the nearest boundary, advances
// and checks limit and height band; a blocking answer goes straight to its hit.
// The block takes one request at a time; ready is high only while the sequencer is
// idle, and a finished response waits in the output register without holding up
// the next request. The height band register may be written whenever no ray work
// is in flight.
`include "voxel_ray_traversal_top_assert.svh"
module voxel_ray_traversal_top (
   input  logic                                clock,
   input  logic                                reset,
   vrt_req_if.sink                             req_if,
   vrt_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [vrt_pkg::HEIGHT_W-1:0]        csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL,
      ST_SEL,
      ST_ADV,
      ST_VISIT,
      ST_HIT
   } state_type;

   state_type                          state_ff, state_in;
   vrt_pkg::axis_type                  axis_ff, axis_in;
   vrt_pkg::axis_type                  sel_ff, sel_in;
   logic                               ray_active_ff, ray_active_in;
   logic [vrt_pkg::HEIGHT_W-1:0]       height_ff, height_in;
   logic [2:0][15:0]                   voxel_ff, voxel_in;
   logic [2:0][15:0]                   prev_ff, prev_in;
   logic [2:0][31:0]                   bound_ff, bound_in;
   logic [2:0][31:0]                   cross_ff, cross_in;
   logic [2:0]                         neg_ff, neg_in;
   logic [2:0][15:0]                   frac_ff, frac_in;
   logic [2:0][15:0]                   mag_ff, mag_in;
   logic [2:0]                         face_ff, face_in;
   logic [31:0]                        trav_ff, trav_in;
   logic [31:0]                        limit_ff, limit_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   vrt_pkg::rsp_type                   rsp_ff, rsp_in;

   vrt_pkg::axis_type                  cur;
   logic [31:0]                        cur_bound;
   logic [31:0]                        cur_cross;
   logic [15:0]                        cur_mag;
   logic [15:0]                        cur_frac;
   logic [15:0]                        cur_voxel;
   logic                               cur_neg;
   logic [2:0]                         cur_face;
   logic [16:0]                        first_dist;
   logic [48:0]                        product;
   logic [32:0]                        step_sum;
   logic                               out_free;
   logic                               accept;
   logic                               is_miss;
   logic                               div_start;
   logic                               div_done;
   logic [30:0]                        div_quo;
   logic [2:0][31:0]                   req_origin;
   logic [2:0][15:0]                   req_dir;

   vrt_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (cur_mag),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_origin = {req_if.origin_z, req_if.origin_y, req_if.origin_x};
   assign req_dir    = {req_if.dir_z, req_if.dir_y, req_if.dir_x};
   assign accept     = req_if.valid && req_if.ready;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign div_start  = (state_ff == ST_DIV_GO);

   // Select the axis being worked on: the stepping axis while advancing, else setup.
   always_comb begin
      cur       = (state_ff == ST_ADV) ? sel_ff : axis_ff;
      cur_bound = '0;
      cur_cross = '0;
      cur_mag   = '0;
      cur_frac  = '0;
      cur_voxel = '0;
      cur_neg   = 1'b0;
      for (int i = 0; i < vrt_pkg::NUM_AXES; i++) begin
         if (vrt_pkg::AXIS_W'(i) == cur) begin
            cur_bound = bound_ff[i];
            cur_cross = cross_ff[i];
            cur_mag   = mag_ff[i];
            cur_frac  = frac_ff[i];
            cur_voxel = voxel_ff[i];
            cur_neg   = neg_ff[i];
         end
      end
      case (cur)
         vrt_pkg::AXIS_X: cur_face = cur_neg ? vrt_pkg::FACE_POS_X : vrt_pkg::FACE_NEG_X;
         vrt_pkg::AXIS_Y: cur_face = cur_neg ? vrt_pkg::FACE_POS_Y : vrt_pkg::FACE_NEG_Y;
         vrt_pkg::AXIS_Z: cur_face = cur_neg ? vrt_pkg::FACE_POS_Z : vrt_pkg::FACE_NEG_Z;
         default:         cur_face = vrt_pkg::FACE_POS_Y;
      endcase
   end

   // First boundary product, the saturating step sum and the miss check.
   always_comb begin
      first_dist = cur_neg ? {1'b0, cur_frac} : 17'(vrt_pkg::ONE_Q16 - {1'b0, cur_frac});
      product    = 49'(first_dist) * 49'(cur_cross);
      step_sum   = {1'b0, cur_bound} + {1'b0, cur_cross};
      is_miss    = (trav_ff > limit_ff) || (trav_ff == vrt_pkg::SAT32) ||
                   voxel_ff[1][15] || (voxel_ff[1] >= {1'b0, height_ff});
   end

   // Sequencer and ray state updates.
   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      sel_in        = sel_ff;
      ray_active_in = ray_active_ff;
      height_in     = csr_wr_en ? csr_wr_data : height_ff;
      voxel_in      = voxel_ff;
      prev_in       = prev_ff;
      bound_in      = bound_ff;
      cross_in      = cross_ff;
      neg_in        = neg_ff;
      frac_in       = frac_ff;
      mag_in        = mag_ff;
      face_in       = face_ff;
      trav_in       = trav_ff;
      limit_in      = limit_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = (rsp_valid_ff && rsp_if.ready) ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.op == vrt_pkg::OP_START) begin
                  // Load the new ray, dropping any ray in progress.
                  for (int i = 0; i < vrt_pkg::NUM_AXES; i++) begin
                     voxel_in[i] = req_origin[i][31:16];
                     prev_in[i]  = req_origin[i][31:16];
                     frac_in[i]  = req_origin[i][15:0];
                     neg_in[i]   = req_dir[i][15];
                     mag_in[i]   = req_dir[i][15] ? 16'(~req_dir[i] + 16'd1) : req_dir[i];
                  end
                  face_in  = vrt_pkg::FACE_POS_Y;
                  trav_in  = '0;
                  limit_in = req_if.max_distance;
                  axis_in  = vrt_pkg::AXIS_X;
                  state_in = ST_DIV_GO;
               end else if (ray_active_ff) begin
                  state_in = req_if.voxel_solid ? ST_HIT : ST_SEL;
               end
            end
         end

         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end

         ST_DIV_WAIT: begin
            if (div_done) begin
               for (int i = 0; i < vrt_pkg::NUM_AXES; i++) begin
                  if (vrt_pkg::AXIS_W'(i) == cur) begin
                     cross_in[i] = (cur_mag == '0) ? vrt_pkg::SAT32 : {1'b0, div_quo};
                  end
               end
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            for (int i = 0; i < vrt_pkg::NUM_AXES; i++) begin
               if (vrt_pkg::AXIS_W'(i) == cur) begin
                  bound_in[i] = product[48] ? vrt_pkg::SAT32 : product[47:16];
               end
            end
            case (axis_ff)
               vrt_pkg::AXIS_X: begin
                  axis_in  = vrt_pkg::AXIS_Y;
                  state_in = ST_DIV_GO;
               end
               vrt_pkg::AXIS_Y: begin
                  axis_in  = vrt_pkg::AXIS_Z;
                  state_in = ST_DIV_GO;
               end
               default: begin
                  state_in = ST_VISIT;
               end
            endcase
         end

         ST_SEL: begin
            // Pick the axis with the nearest boundary; ties go to the later axis.
            prev_in = voxel_ff;
            if (bound_ff[0] < bound_ff[1] && bound_ff[0] < bound_ff[2]) begin
               sel_in = vrt_pkg::AXIS_X;
            end else if (bound_ff[1] < bound_ff[2]) begin
               sel_in = vrt_pkg::AXIS_Y;
            end else begin
               sel_in = vrt_pkg::AXIS_Z;
            end
            state_in = ST_ADV;
         end

         ST_ADV: begin
            // Advance one voxel along the chosen axis.
            trav_in = cur_bound;
            face_in = cur_face;
            for (int i = 0; i < vrt_pkg::NUM_AXES; i++) begin
               if (vrt_pkg::AXIS_W'(i) == cur) begin
                  bound_in[i] = step_sum[32] ? vrt_pkg::SAT32 : step_sum[31:0];
                  voxel_in[i] = cur_neg ? 16'(cur_voxel - 16'd1) : 16'(cur_voxel + 16'd1);
               end
            end
            state_in = ST_VISIT;
         end

         ST_VISIT: begin
            // Report a query, or a miss when past the limit, saturated or out of the band.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (is_miss) begin
                  ray_active_in   = 1'b0;
                  rsp_in.kind     = vrt_pkg::KIND_MISS;
                  rsp_in.voxel    = '0;
                  rsp_in.prior    = '0;
                  rsp_in.face     = vrt_pkg::FACE_POS_Y;
                  rsp_in.distance = '0;
               end else begin
                  ray_active_in   = 1'b1;
                  rsp_in.kind     = vrt_pkg::KIND_QUERY;
                  rsp_in.voxel    = voxel_ff;
                  rsp_in.prior    = prev_ff;
                  rsp_in.face     = face_ff;
                  rsp_in.distance = trav_ff;
               end
               state_in = ST_IDLE;
            end
         end

         ST_HIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               ray_active_in   = 1'b0;
               rsp_in.kind     = vrt_pkg::KIND_HIT;
               rsp_in.voxel    = voxel_ff;
               rsp_in.prior    = prev_ff;
               rsp_in.face     = face_ff;
               rsp_in.distance = trav_ff;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sel_ff   <= sel_in;
      voxel_ff <= voxel_in;
      prev_ff  <= prev_in;
      bound_ff <= bound_in;
      cross_ff <= cross_in;
      neg_ff   <= neg_in;
      frac_ff  <= frac_in;
      mag_ff   <= mag_in;
      face_ff  <= face_in;
      trav_ff  <= trav_in;
      limit_ff <= limit_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         axis_ff       <= vrt_pkg::AXIS_X;
         ray_active_ff <= 1'b0;
         height_ff     <= vrt_pkg::DEFAULT_HEIGHT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         ray_active_ff <= ray_active_in;
         height_ff     <= height_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Drive request ready from the sequencer state and the response channel from the output register.
   assign req_if.ready    = (state_ff == ST_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.kind     = rsp_ff.kind;
   assign rsp_if.voxel_x  = rsp_ff.voxel[0];
   assign rsp_if.voxel_y  = rsp_ff.voxel[1];
   assign rsp_if.voxel_z  = rsp_ff.voxel[2];
   assign rsp_if.prior_x  = rsp_ff.prior[0];
   assign rsp_if.prior_y  = rsp_ff.prior[1];
   assign rsp_if.prior_z  = rsp_ff.prior[2];
   assign rsp_if.face     = rsp_ff.face;
   assign rsp_if.distance = rsp_ff.distance;

   // Checks on the sequencer and the response register.
   `VRT_ASSERT_NEXT(a_start_busy, accept && req_if.op == vrt_pkg::OP_START, !req_if.ready, "start request did not make the block busy")
   `VRT_ASSERT_NOW(a_miss_clear, rsp_valid_ff && rsp_ff.kind == vrt_pkg::KIND_MISS, rsp_ff.distance == '0 && rsp_ff.face == vrt_pkg::FACE_POS_Y, "miss response carries stale fields")
   `VRT_ASSERT_NOW(a_div_sync, div_done, state_ff == ST_DIV_WAIT, "divider finished outside the setup wait")
   `VRT_ASSERT_NOW(a_hit_active, state_ff == ST_HIT, ray_active_ff, "hit reported without an active ray")

endmodule

// File: test/tb.sv
// Testbench for the voxel ray traversal block: directed and random ray walks against a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 150;
   localparam int RSP_HOLD_LEN  = 400;
   localparam int PHASE_RSPS    = 170;

   typedef struct packed {
      logic             op;
      logic [2:0][31:0] origin;
      logic [2:0][15:0] dir;
      logic [31:0]      max_distance;
      logic             voxel_solid;
   } ray_req_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_wr_en;
   logic [vrt_pkg::HEIGHT_W-1:0] csr_wr_data;

   vrt_req_if req_bus ();
   vrt_rsp_if rsp_bus ();

   voxel_ray_traversal_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted ray state
   logic [vrt_pkg::HEIGHT_W-1:0] band_height;
   logic                         ray_live;
   logic [2:0][15:0]             cur_voxel;
   logic [2:0][15:0]             last_voxel;
   logic [2:0][31:0]             next_cross;
   logic [2:0][31:0]             cross_step;
   logic [2:0]                   step_down;
   logic [2:0]                   face_in;
   logic [31:0]                  ray_dist;
   logic [31:0]                  ray_limit;

   vrt_pkg::rsp_type pending_voxel_rsp[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      rsp_hold_cycles = 0;
   int      rsp_stall_left = 0;
   bit      req_gaps_on = 1'b1;
   bit      rsp_gaps_on = 1'b1;
   bit      last_had_rsp;

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void load_axis(vrt_pkg::axis_type ax, logic [31:0] org,
                                     logic [15:0] dir);
      logic [16:0] mag;
      logic [16:0] span;
      logic [63:0] prod;
      step_down[ax] = dir[15];
      mag = dir[15] ? (vrt_pkg::ONE_Q16 - {1'b0, dir}) : {1'b0, dir};
      cross_step[ax] = (mag == '0) ? vrt_pkg::SAT32
                                   : 32'(64'(vrt_pkg::RECIP_DIVIDEND) / 64'(mag));
      cur_voxel[ax] = org[31:16];
      // distance to the first boundary in the direction of travel
      span = dir[15] ? {1'b0, org[15:0]} : (vrt_pkg::ONE_Q16 - {1'b0, org[15:0]});
      prod = (64'(span) * 64'(cross_step[ax])) >> 16;
      next_cross[ax] = (prod > 64'(vrt_pkg::SAT32)) ? vrt_pkg::SAT32 : prod[31:0];
   endfunction

   // Query the current voxel, or drop the ray when past the limit or out of band
   function automatic vrt_pkg::rsp_type visit_voxel();
      vrt_pkg::rsp_type rsp;
      rsp = '0;
      rsp.kind = vrt_pkg::KIND_MISS;
      rsp.face = vrt_pkg::FACE_POS_Y;
      if (ray_dist == vrt_pkg::SAT32 || ray_dist > ray_limit ||
          cur_voxel[vrt_pkg::AXIS_Y][15] ||
          cur_voxel[vrt_pkg::AXIS_Y] >= {1'b0, band_height}) begin
         ray_live = 1'b0;
      end else begin
         ray_live = 1'b1;
         rsp.kind = vrt_pkg::KIND_QUERY;
         rsp.voxel = cur_voxel;
         rsp.prior = last_voxel;
         rsp.face = face_in;
         rsp.distance = ray_dist;
      end
      return rsp;
   endfunction

   function automatic bit trace_ray(input ray_req_type r, output vrt_pkg::rsp_type rsp);
      vrt_pkg::axis_type ax;
      logic [32:0]       sum;
      rsp = '0;
      if (r.op == vrt_pkg::OP_START) begin
         load_axis(vrt_pkg::AXIS_X, r.origin[vrt_pkg::AXIS_X], r.dir[vrt_pkg::AXIS_X]);
         load_axis(vrt_pkg::AXIS_Y, r.origin[vrt_pkg::AXIS_Y], r.dir[vrt_pkg::AXIS_Y]);
         load_axis(vrt_pkg::AXIS_Z, r.origin[vrt_pkg::AXIS_Z], r.dir[vrt_pkg::AXIS_Z]);
         last_voxel = cur_voxel;
         face_in = vrt_pkg::FACE_POS_Y;
         ray_dist = '0;
         ray_limit = r.max_distance;
         rsp = visit_voxel();
         return 1'b1;
      end
      if (!ray_live) return 1'b0;
      if (r.voxel_solid) begin
         ray_live = 1'b0;
         rsp.kind = vrt_pkg::KIND_HIT;
         rsp.voxel = cur_voxel;
         rsp.prior = last_voxel;
         rsp.face = face_in;
         rsp.distance = ray_dist;
         return 1'b1;
      end
      // advance along the axis with the nearest boundary
      last_voxel = cur_voxel;
      if (next_cross[vrt_pkg::AXIS_X] < next_cross[vrt_pkg::AXIS_Y] &&
          next_cross[vrt_pkg::AXIS_X] < next_cross[vrt_pkg::AXIS_Z])
         ax = vrt_pkg::AXIS_X;
      else if (next_cross[vrt_pkg::AXIS_Y] < next_cross[vrt_pkg::AXIS_Z])
         ax = vrt_pkg::AXIS_Y;
      else
         ax = vrt_pkg::AXIS_Z;
      ray_dist = next_cross[ax];
      sum = {1'b0, next_cross[ax]} + {1'b0, cross_step[ax]};
      next_cross[ax] = sum[32] ? vrt_pkg::SAT32 : sum[31:0];
      cur_voxel[ax] = step_down[ax] ? cur_voxel[ax] - 16'd1 : cur_voxel[ax] + 16'd1;
      case (ax)
         vrt_pkg::AXIS_X:
            face_in = step_down[ax] ? vrt_pkg::FACE_POS_X : vrt_pkg::FACE_NEG_X;
         vrt_pkg::AXIS_Y:
            face_in = step_down[ax] ? vrt_pkg::FACE_POS_Y : vrt_pkg::FACE_NEG_Y;
         default:
            face_in = step_down[ax] ? vrt_pkg::FACE_POS_Z : vrt_pkg::FACE_NEG_Z;
      endcase
      rsp = visit_voxel();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- request builders

   function automatic ray_req_type answer_req(logic solid);
      ray_req_type r;
      r.op = vrt_pkg::OP_ANSWER;
      r.origin = {$urandom, $urandom, $urandom};
      r.dir = {16'($urandom), 16'($urandom), 16'($urandom)};
      r.max_distance = $urandom;
      r.voxel_solid = solid;
      return r;
   endfunction

   function automatic ray_req_type start_req(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                             logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                                             logic [31:0] lim);
      ray_req_type r;
      r.op = vrt_pkg::OP_START;
      r.origin = {oz, oy, ox};
      r.dir = {dz, dy, dx};
      r.max_distance = lim;
      r.voxel_solid = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic ray_req_type random_start();
      ray_req_type r;
      int          top_y;
      int          i;
      r = answer_req(1'($urandom_range(0, 1)));
      r.op = vrt_pkg::OP_START;
      top_y = (band_height == '0) ? 0 : int'(band_height) - 1;
      for (i = 0; i < 3; i++) begin
         case ($urandom_range(0, 9))
            0:       r.dir[i] = 16'h0000;
            1:       r.dir[i] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            2, 3:    r.dir[i] = 16'($urandom);
            default: begin
               r.dir[i] = 16'($urandom_range(16'h0400, 16'h4000));
               if ($urandom_range(0, 1)) r.dir[i] = -r.dir[i];
            end
         endcase
         if (i == vrt_pkg::AXIS_Y) begin
            if ($urandom_range(0, 7) == 0)
               r.origin[i] = $urandom;
            else
               r.origin[i] = {16'($urandom_range(0, top_y)), 16'($urandom)};
         end else begin
            case ($urandom_range(0, 7))
               0:       r.origin[i] = $urandom;
               1:       r.origin[i] = {16'h7FFE + 16'($urandom_range(0, 3)), 16'($urandom)};
               default: r.origin[i] = {16'($urandom_range(0, 63)) - 16'd32, 16'($urandom)};
            endcase
         end
      end
      case ($urandom_range(0, 7))
         0:       r.max_distance = $urandom;
         1:       r.max_distance = vrt_pkg::SAT32;
         default: r.max_distance = {16'($urandom_range(0, 48)), 16'($urandom)};
      endcase
      return r;
   endfunction

   // Mostly well-formed walks; a little noise from restarts and stray answers
   function automatic ray_req_type next_walk_item();
      if (!ray_live)
         return ($urandom_range(0, 19) == 0) ? answer_req(1'($urandom_range(0, 1)))
                                             : random_start();
      if ($urandom_range(0, 29) == 0) return random_start();
      return answer_req($urandom_range(0, 15) == 0);
   endfunction

   // ---------------------------------------------------------------- channel drivers

   task automatic send_request(input ray_req_type r);
      int               gap;
      vrt_pkg::rsp_type rsp;
      gap = req_gaps_on ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.op = r.op;
      req_bus.origin_x = r.origin[vrt_pkg::AXIS_X];
      req_bus.origin_y = r.origin[vrt_pkg::AXIS_Y];
      req_bus.origin_z = r.origin[vrt_pkg::AXIS_Z];
      req_bus.dir_x = r.dir[vrt_pkg::AXIS_X];
      req_bus.dir_y = r.dir[vrt_pkg::AXIS_Y];
      req_bus.dir_z = r.dir[vrt_pkg::AXIS_Z];
      req_bus.max_distance = r.max_distance;
      req_bus.voxel_solid = r.voxel_solid;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      last_had_rsp = trace_ray(r, rsp);
      if (last_had_rsp) pending_voxel_rsp.push_back(rsp);
      if ($urandom_range(0, 39) == 0) req_gaps_on = ~req_gaps_on;
   endtask

   // Hold the request channel idle until every predicted response has arrived
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_voxel_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_world_height(input logic [vrt_pkg::HEIGHT_W-1:0] h);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = h;
      @(negedge clock);
      csr_wr_en = 1'b0;
      band_height = h;
   endtask

   // Drive response ready: long hold-off first, then per-response stalls
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_cycles--;
         end else if (rsp_stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      vrt_pkg::rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_voxel_rsp.size() == 0) begin
            $error("response with no request waiting on it");
            error_count++;
         end else begin
            want = pending_voxel_rsp.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_bus.kind));
            check_field("voxel_x", 32'(want.voxel[vrt_pkg::AXIS_X]),
                        32'($unsigned(rsp_bus.voxel_x)));
            check_field("voxel_y", 32'(want.voxel[vrt_pkg::AXIS_Y]),
                        32'($unsigned(rsp_bus.voxel_y)));
            check_field("voxel_z", 32'(want.voxel[vrt_pkg::AXIS_Z]),
                        32'($unsigned(rsp_bus.voxel_z)));
            check_field("prior_x", 32'(want.prior[vrt_pkg::AXIS_X]),
                        32'($unsigned(rsp_bus.prior_x)));
            check_field("prior_y", 32'(want.prior[vrt_pkg::AXIS_Y]),
                        32'($unsigned(rsp_bus.prior_y)));
            check_field("prior_z", 32'(want.prior[vrt_pkg::AXIS_Z]),
                        32'($unsigned(rsp_bus.prior_z)));
            check_field("face", 32'(want.face), 32'(rsp_bus.face));
            check_field("distance", want.distance, rsp_bus.distance);
         end
         if ($urandom_range(0, 39) == 0) rsp_gaps_on = ~rsp_gaps_on;
         rsp_stall_left = rsp_gaps_on ? $urandom_range(0, 10) : 0;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed_rays();
      // stray answer with no ray loaded
      send_request(answer_req(1'b1));
      // straight walk along +x, then hit
      send_request(start_req(32'h0000_8000, 32'h000A_4000, 32'h0000_C000,
                             16'h4000, 16'h0000, 16'h0000, vrt_pkg::SAT32));
      send_request(answer_req(1'b0));
      send_request(answer_req(1'b0));
      send_request(answer_req(1'b1));
      // extreme origins and directions, x wraps
      send_request(start_req(32'h8000_0000, 32'h0005_0000, 32'h7FFF_FFFF,
                             16'h8000, 16'h7FFF, 16'h8000, vrt_pkg::SAT32));
      send_request(answer_req(1'b0));
      send_request(answer_req(1'b0));
      // restart while a ray is live, under a short limit
      send_request(start_req(32'h0001_8000, 32'h0003_8000, 32'hFFFD_C000,
                             16'h2000, 16'hE000, 16'h1000, 32'h0002_0000));
      send_request(answer_req(1'b0));
      send_request(answer_req(1'b0));
      send_request(answer_req(1'b0));
      // zero direction saturates the crossing steps
      send_request(start_req($urandom, 32'h0010_1234, $urandom, 16'h0, 16'h0, 16'h0,
                             vrt_pkg::SAT32));
      send_request(answer_req(1'b0));
      // zero limit with three-way tie on boundaries
      send_request(start_req(32'h0000_4000, 32'h0001_4000, 32'h0000_4000,
                             16'h4000, 16'h4000, 16'h4000, 32'h0));
      send_request(answer_req(1'b0));
      // x ties y: y steps first, then x
      send_request(start_req(32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                             16'h4000, 16'h4000, 16'h2000, vrt_pkg::SAT32));
      send_request(answer_req(1'b0));
      send_request(answer_req(1'b0));
      send_request(answer_req(1'b1));
      // start below and above the height band
      send_request(start_req(32'h0, 32'hFFFF_8000, 32'h0, 16'h4000, 16'h4000, 16'h4000,
                             vrt_pkg::SAT32));
      send_request(start_req(32'h0, 32'h7FFF_FFFF, 32'h0, 16'h4000, 16'h4000, 16'h4000,
                             vrt_pkg::SAT32));
      // step out of the top layer
      send_request(start_req(32'h0000_8000, 32'h00FF_8000, 32'h0000_8000,
                             16'h0, 16'h4000, 16'h0, vrt_pkg::SAT32));
      send_request(answer_req(1'b0));
   endtask

   task automatic test_band_limits();
      set_world_height(15'd1);
      send_request(start_req(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                             16'h0, 16'h4000, 16'h0, vrt_pkg::SAT32));
      send_request(answer_req(1'b0));
      // no layer at all: any start misses
      set_world_height(15'd0);
      send_request(start_req(32'h0000_8000, 32'h0000_0000, 32'h0000_8000,
                             16'h4000, 16'h0, 16'h0, vrt_pkg::SAT32));
      set_world_height(15'h7FFF);
      send_request(start_req(32'h0000_8000, 32'h7FFE_8000, 32'h0000_8000,
                             16'h0, 16'h4000, 16'h0, vrt_pkg::SAT32));
      send_request(answer_req(1'b0));
   endtask

   task automatic test_stalled_responses();
      int n;
      set_world_height(vrt_pkg::DEFAULT_HEIGHT);
      rsp_hold_cycles = RSP_HOLD_LEN;
      for (n = 0; n < 12; n++) send_request(next_walk_item());
      // pause the sender mid-walk until the block has emptied
      drain_results();
      for (n = 0; n < 10; n++) send_request(next_walk_item());
   endtask

   task automatic test_random_walks();
      logic [vrt_pkg::HEIGHT_W-1:0] heights[6];
      int                           phase;
      int                           produced;
      heights = '{15'd256, 15'd1, 15'h7FFF, 15'd8, 15'd64, 15'($urandom_range(1, 32767))};
      for (phase = 0; phase < 6; phase++) begin
         set_world_height(heights[phase]);
         produced = 0;
         while (produced < PHASE_RSPS) begin
            send_request(next_walk_item());
            if (last_had_rsp) produced++;
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.op = vrt_pkg::OP_START;
      req_bus.origin_x = '0;
      req_bus.origin_y = '0;
      req_bus.origin_z = '0;
      req_bus.dir_x = '0;
      req_bus.dir_y = '0;
      req_bus.dir_z = '0;
      req_bus.max_distance = '0;
      req_bus.voxel_solid = 1'b0;
      band_height = vrt_pkg::DEFAULT_HEIGHT;
      ray_live = 1'b0;
      cur_voxel = '0;
      last_voxel = '0;
      next_cross = '0;
      cross_step = '0;
      step_down = '0;
      face_in = vrt_pkg::FACE_POS_Y;
      ray_dist = '0;
      ray_limit = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_rays();
      test_band_limits();
      test_stalled_responses();
      test_random_walks();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
